// ----- design/triangle_fill_rasterizer_defines.svh -----
// assertion macros for the triangle fill rasterizer
`ifndef TRIANGLE_FILL_RASTERIZER_DEFINES_SVH
`define TRIANGLE_FILL_RASTERIZER_DEFINES_SVH

// implication in the same cycle
`define TFR_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication in the next cycle
`define TFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tfr_pkg.sv -----
// shared types, constants and helpers of the triangle fill rasterizer
`timescale 1ns / 1ps
package tfr_pkg;
	localparam int MAX_WIDTH_DEF  = 128;
	localparam int MAX_HEIGHT_DEF = 128;

	localparam int CW     = 16;
	localparam int EW     = 40;
	localparam int CNT_W  = 15;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	localparam int IN_DW  = 128;
	localparam int OUT_DW = 48;

	localparam logic OP_FILL = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] REG_CLIP_LEFT    = 3'd2;
	localparam logic [2:0] REG_CLIP_TOP     = 3'd3;
	localparam logic [2:0] REG_CLIP_SPAN_X  = 3'd4;
	localparam logic [2:0] REG_CLIP_SPAN_Y  = 3'd5;

	typedef struct packed {
		logic load;
		logic clear;
		logic box;
		logic mul;
		logic edge_init;
		logic step;
		logic read_mem;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_read;
		logic skip;
		logic walk_last;
		logic pipe_busy;
		logic out_free;
	} status_t;

	// exact floor(v / 255) for v up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = 17'(v) + 17'(v >> 8) + 17'd1;
		return t[15:8];
	endfunction
endpackage

// ----- design/tfr_ctrl.sv -----
// controller state machine of the triangle fill rasterizer
`timescale 1ns / 1ps
module tfr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tfr_pkg::status_t status,
	output tfr_pkg::cmd_t    cmd
);
	import tfr_pkg::*;

	typedef enum logic [8:0] {
		ST_CLEAR    = 9'b000000001,
		ST_IDLE     = 9'b000000010,
		ST_BOX      = 9'b000000100,
		ST_MUL      = 9'b000001000,
		ST_EDGE     = 9'b000010000,
		ST_WALK     = 9'b000100000,
		ST_DRAIN    = 9'b001000000,
		ST_READ_MEM = 9'b010000000,
		ST_DONE     = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_BOX;
				end
			end
			ST_BOX: begin
				cmd.box = 1'b1;
				state_d = status.is_read ? ST_READ_MEM : ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_EDGE;
			end
			ST_EDGE: begin
				cmd.edge_init = 1'b1;
				state_d = status.skip ? ST_DONE : ST_WALK;
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (status.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_READ_MEM: begin
				cmd.read_mem = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end
endmodule

// ----- design/tfr_datapath.sv -----
// datapath of the triangle fill rasterizer: registers, edge walker, blend pipe, framebuffer
`timescale 1ns / 1ps
`include "triangle_fill_rasterizer_defines.svh"
module tfr_datapath #(
	parameter int MAX_WIDTH  = tfr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tfr_pkg::MAX_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tfr_pkg::cmd_t              cmd,
	output tfr_pkg::status_t           status,
	input  logic                       cfg_valid,
	input  logic [2:0]                 cfg_index,
	input  logic [7:0]                 cfg_data,
	input  logic [tfr_pkg::IN_DW-1:0]  s_tdata,
	input  logic                       s_tuser,
	input  logic                       m_tready,
	output logic                       m_tvalid,
	output logic [tfr_pkg::OUT_DW-1:0] m_tdata
);
	import tfr_pkg::*;

	localparam int FB_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = (FB_SIZE > 1) ? $clog2(FB_SIZE) : 1;
	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam logic [AW-1:0] CLR_LAST = AW'(FB_SIZE - 1);

	// configuration
	logic [7:0] frame_width_q, frame_height_q, clip_left_q, clip_top_q;
	logic [7:0] clip_span_x_q, clip_span_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 8'd128;
			frame_height_q <= 8'd128;
			clip_left_q    <= 8'd0;
			clip_top_q     <= 8'd0;
			clip_span_x_q  <= 8'd128;
			clip_span_y_q  <= 8'd128;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_CLIP_LEFT:    clip_left_q    <= cfg_data;
				REG_CLIP_TOP:     clip_top_q     <= cfg_data;
				REG_CLIP_SPAN_X:  clip_span_x_q  <= cfg_data;
				REG_CLIP_SPAN_Y:  clip_span_y_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [7:0] w_eff, h_eff;
	assign w_eff = ({24'd0, frame_width_q} > 32'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : frame_width_q;
	assign h_eff = ({24'd0, frame_height_q} > 32'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT)
		: frame_height_q;

	// request capture
	logic                 op_q;
	logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [7:0]           red_q, green_q, blue_q, alpha_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= s_tuser;
			ax_q    <= s_tdata[15:0];
			ay_q    <= s_tdata[31:16];
			bx_q    <= s_tdata[47:32];
			by_q    <= s_tdata[63:48];
			cx_q    <= s_tdata[79:64];
			cy_q    <= s_tdata[95:80];
			red_q   <= s_tdata[103:96];
			green_q <= s_tdata[111:104];
			blue_q  <= s_tdata[119:112];
			alpha_q <= s_tdata[127:120];
		end
	end

	// bounding box and edge deltas
	logic signed [17:0] vminx, vmaxx, vminy, vmaxy, lo_x, lo_y, hi_x, hi_y;
	logic [8:0]         end_x, end_y, lim_x, lim_y;
	logic signed [17:0] minx_q, maxx_q, miny_q, maxy_q;
	logic signed [16:0] d_abx_q, d_aby_q, d_bcx_q, d_bcy_q, d_cax_q, d_cay_q;
	logic               rd_ok_q;
	logic [AW-1:0]      rd_addr_q;
	logic [16:0]        rd_lin;

	always_comb begin
		vminx = 18'(ax_q);
		if (18'(bx_q) < vminx) vminx = 18'(bx_q);
		if (18'(cx_q) < vminx) vminx = 18'(cx_q);
		vmaxx = 18'(ax_q);
		if (18'(bx_q) > vmaxx) vmaxx = 18'(bx_q);
		if (18'(cx_q) > vmaxx) vmaxx = 18'(cx_q);
		vminy = 18'(ay_q);
		if (18'(by_q) < vminy) vminy = 18'(by_q);
		if (18'(cy_q) < vminy) vminy = 18'(cy_q);
		vmaxy = 18'(ay_q);
		if (18'(by_q) > vmaxy) vmaxy = 18'(by_q);
		if (18'(cy_q) > vmaxy) vmaxy = 18'(cy_q);
		end_x = {1'b0, clip_left_q} + {1'b0, clip_span_x_q};
		end_y = {1'b0, clip_top_q} + {1'b0, clip_span_y_q};
		lim_x = (end_x < {1'b0, w_eff}) ? end_x : {1'b0, w_eff};
		lim_y = (end_y < {1'b0, h_eff}) ? end_y : {1'b0, h_eff};
		lo_x  = $signed({10'd0, clip_left_q});
		lo_y  = $signed({10'd0, clip_top_q});
		hi_x  = $signed({9'd0, lim_x}) - 18'sd1;
		hi_y  = $signed({9'd0, lim_y}) - 18'sd1;
		rd_lin = 17'(ay_q[7:0] * w_eff) + 17'(ax_q[7:0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.box) begin
			minx_q  <= (vminx > lo_x) ? vminx : lo_x;
			maxx_q  <= (vmaxx < hi_x) ? vmaxx : hi_x;
			miny_q  <= (vminy > lo_y) ? vminy : lo_y;
			maxy_q  <= (vmaxy < hi_y) ? vmaxy : hi_y;
			d_abx_q <= 17'(bx_q) - 17'(ax_q);
			d_aby_q <= 17'(by_q) - 17'(ay_q);
			d_bcx_q <= 17'(cx_q) - 17'(bx_q);
			d_bcy_q <= 17'(cy_q) - 17'(by_q);
			d_cax_q <= 17'(ax_q) - 17'(cx_q);
			d_cay_q <= 17'(ay_q) - 17'(cy_q);
			rd_ok_q <= !ax_q[CW-1] && !ay_q[CW-1]
				&& (ax_q < $signed({8'd0, w_eff})) && (ay_q < $signed({8'd0, h_eff}));
			rd_addr_q <= AW'(rd_lin);
		end
	end

	// edge products at the box corner
	logic signed [18:0] oxa, oya, oxb, oyb, oxc, oyc;
	logic signed [35:0] p1a_q, p1b_q, p2a_q, p2b_q, p3a_q, p3b_q;
	logic signed [33:0] pa_q, pb_q;
	logic [AW-1:0]      row_base_q;
	logic [XW-1:0]      x_q;
	logic [YW-1:0]      y_q;

	assign oxa = 19'(minx_q) - 19'(ax_q);
	assign oya = 19'(miny_q) - 19'(ay_q);
	assign oxb = 19'(minx_q) - 19'(bx_q);
	assign oyb = 19'(miny_q) - 19'(by_q);
	assign oxc = 19'(minx_q) - 19'(cx_q);
	assign oyc = 19'(miny_q) - 19'(cy_q);

	logic signed [EW-1:0] e1_q, e2_q, e3_q, r1_q, r2_q, r3_q;
	logic                 last_x, last_y, covered;

	assign last_x  = x_q == minx_q[XW-1:0] + (maxx_q[XW-1:0] - minx_q[XW-1:0]);
	assign last_y  = y_q == maxy_q[YW-1:0];
	assign covered = (e1_q >= 0 && e2_q >= 0 && e3_q >= 0)
		|| (e1_q <= 0 && e2_q <= 0 && e3_q <= 0);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p1a_q      <= d_abx_q * oya;
			p1b_q      <= d_aby_q * oxa;
			p2a_q      <= d_bcx_q * oyb;
			p2b_q      <= d_bcy_q * oxb;
			p3a_q      <= d_cax_q * oyc;
			p3b_q      <= d_cay_q * oxc;
			pa_q       <= d_abx_q * d_cay_q;
			pb_q       <= d_aby_q * d_cax_q;
			row_base_q <= AW'(miny_q[7:0] * w_eff);
			x_q        <= minx_q[XW-1:0];
			y_q        <= miny_q[YW-1:0];
		end else if (cmd.edge_init) begin
			e1_q <= EW'(p1a_q) - EW'(p1b_q);
			e2_q <= EW'(p2a_q) - EW'(p2b_q);
			e3_q <= EW'(p3a_q) - EW'(p3b_q);
			r1_q <= EW'(p1a_q) - EW'(p1b_q);
			r2_q <= EW'(p2a_q) - EW'(p2b_q);
			r3_q <= EW'(p3a_q) - EW'(p3b_q);
		end else if (cmd.step) begin
			if (!last_x) begin
				x_q  <= x_q + XW'(1);
				e1_q <= e1_q - EW'(d_aby_q);
				e2_q <= e2_q - EW'(d_bcy_q);
				e3_q <= e3_q - EW'(d_cay_q);
			end else begin
				x_q        <= minx_q[XW-1:0];
				y_q        <= y_q + YW'(1);
				row_base_q <= row_base_q + AW'(w_eff);
				r1_q       <= r1_q + EW'(d_abx_q);
				r2_q       <= r2_q + EW'(d_bcx_q);
				r3_q       <= r3_q + EW'(d_cax_q);
				e1_q       <= r1_q + EW'(d_abx_q);
				e2_q       <= r2_q + EW'(d_bcx_q);
				e3_q       <= r3_q + EW'(d_cax_q);
			end
		end
	end

	// written pixel count
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= '0;
		end else if (cmd.step && covered && count_q != CNT_MAX) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// framebuffer, rgb only: every stored pixel is opaque
	logic [23:0]   fb_mem [FB_SIZE];
	logic [23:0]   mem_q;
	logic          mem_re, mem_we;
	logic [AW-1:0] mem_raddr, mem_waddr;
	logic [23:0]   mem_wdata;
	logic [AW-1:0] clr_q;

	// blend pipe
	logic          valid_s1, cov_s1, valid_s2, wen_s2;
	logic [AW-1:0] addr_s1, addr_s2;
	logic [15:0]   sum_r_s2, sum_g_s2, sum_b_s2;
	logic [7:0]    inv_alpha;

	assign inv_alpha = ALPHA_OPAQUE - alpha_q;
	assign mem_re    = cmd.step || cmd.read_mem;
	assign mem_raddr = cmd.read_mem ? rd_addr_q : row_base_q + AW'(x_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			clr_q    <= '0;
		end else begin
			valid_s1 <= cmd.step;
			valid_s2 <= valid_s1;
			if (cmd.clear) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		cov_s1   <= covered;
		addr_s1  <= mem_raddr;
		wen_s2   <= cov_s1 && alpha_q != 8'd0;
		addr_s2  <= addr_s1;
		sum_r_s2 <= 16'(red_q * alpha_q) + 16'(mem_q[23:16] * inv_alpha);
		sum_g_s2 <= 16'(green_q * alpha_q) + 16'(mem_q[15:8] * inv_alpha);
		sum_b_s2 <= 16'(blue_q * alpha_q) + 16'(mem_q[7:0] * inv_alpha);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s2;
		mem_wdata = {div255(sum_r_s2), div255(sum_g_s2), div255(sum_b_s2)};
		if (cmd.clear) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (valid_s2 && wen_s2) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fb_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_q <= fb_mem[mem_raddr];
		end
	end

	// result register
	logic             out_valid_q;
	logic [7:0]       out_red_q, out_green_q, out_blue_q, out_alpha_q;
	logic [CNT_W-1:0] out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (op_q == OP_READ) begin
				out_red_q   <= rd_ok_q ? mem_q[23:16] : 8'd0;
				out_green_q <= rd_ok_q ? mem_q[15:8] : 8'd0;
				out_blue_q  <= rd_ok_q ? mem_q[7:0] : 8'd0;
				out_alpha_q <= ALPHA_OPAQUE;
				out_count_q <= '0;
			end else begin
				out_red_q   <= 8'd0;
				out_green_q <= 8'd0;
				out_blue_q  <= 8'd0;
				out_alpha_q <= 8'd0;
				out_count_q <= count_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_count_q, out_alpha_q, out_blue_q, out_green_q, out_red_q};

	assign status.clr_last  = clr_q == CLR_LAST;
	assign status.is_read   = op_q == OP_READ;
	assign status.skip      = minx_q > maxx_q || miny_q > maxy_q || pa_q == pb_q;
	assign status.walk_last = last_x && last_y;
	assign status.pipe_busy = valid_s1 || valid_s2;
	assign status.out_free  = !out_valid_q || m_tready;

	`TFR_ASSERT(a_clear_no_blend, cmd.clear, !valid_s1 && !valid_s2, "blend write during clear")
	`TFR_ASSERT_NEXT(a_pipe_order, valid_s1, valid_s2, "blend stage lost a pixel")
	`TFR_ASSERT(a_count_only_fill, out_valid_q && out_count_q != '0, out_alpha_q == 8'd0,
		"count on a read result")
	`TFR_ASSERT(a_emit_free, cmd.emit, status.out_free, "result overwritten")
endmodule

// ----- design/triangle_fill_rasterizer.sv -----
// top level of the triangle fill rasterizer
`timescale 1ns / 1ps
// usage
// s_* carries one request: tuser is the op (fill or read), tdata the vertices and colour.
// m_* returns one result per request: pixel for a read, written pixel count for a fill.
// cfg_* writes frame size and clip registers; it is always ready and may be used only
// while no request is in flight.
// after reset a clearing pass writes opaque black to all MAX_WIDTH * MAX_HEIGHT pixels,
// one per cycle; s_tready stays low until it ends.
// a read passes through the box and memory read states before its result is registered.
// a fill passes through the box, multiply and edge setup states; then the edge walker
// steps one pixel a cycle over its clipped bounding box through a read, blend, write pipe
// of the framebuffer, which drains; a degenerate or fully clipped triangle skips the walk.
// one request is handled at a time; a new one is taken while the last result waits.
// when the receiver stalls, the result is held and the block waits to present the next.
module triangle_fill_rasterizer #(
	parameter int MAX_WIDTH  = tfr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tfr_pkg::MAX_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// vert_ax, vert_ay, vert_bx, vert_by, vert_cx, vert_cy, src_red, src_green,
	// src_blue, src_alpha
	input  logic [tfr_pkg::IN_DW-1:0]  s_tdata,
	// op
	input  logic                       s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// pix_red, pix_green, pix_blue, pix_alpha, written_count, one pad bit
	output logic [tfr_pkg::OUT_DW-1:0] m_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 cfg_index,
	input  logic [7:0]                 cfg_data
);
	import tfr_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	tfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tfr_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);
endmodule

// ----- tb/tb_top.sv -----
// self-checking bench for the triangle fill rasterizer: random fills and reads against a predictor
`timescale 1ns / 1ps
module tb_top;
	import tfr_pkg::*;

	typedef struct {
		logic              op;
		logic signed [15:0] ax, ay, bx, by, cx, cy;
		logic [7:0]        r, g, b, a;
	} cmd_item_t;

	typedef struct {
		logic [7:0]  r, g, b, a;
		logic [14:0] cnt;
	} pix_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DW-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DW-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	triangle_fill_rasterizer i_dut (.*);

	initial forever #5 clk = ~clk;

	// predictor state
	logic [31:0] fb_model [0:16383];
	int unsigned fw, fh, cl, ct, csx, csy;
	cmd_item_t   pending_cmds[$];
	pix_result_t expected_pix[$];
	int unsigned mismatches = 0, results_seen = 0, fills_done = 0, reads_done = 0;
	longint unsigned cycles = 0;
	bit hold_sender = 1'b0;
	int burst_left = 0, gap_left = 0;

	function automatic logic [31:0] blend_px(logic [31:0] d, cmd_item_t c);
		int unsigned inv;
		logic [7:0] nr, ng, nb;
		if (c.a == 8'hFF) return {8'hFF, c.r, c.g, c.b};
		if (c.a == 8'h00) return d;
		inv = 255 - c.a;
		nr = 8'((c.r * c.a + d[23:16] * inv) / 255);
		ng = 8'((c.g * c.a + d[15:8] * inv) / 255);
		nb = 8'((c.b * c.a + d[7:0] * inv) / 255);
		return {8'hFF, nr, ng, nb};
	endfunction

	function automatic longint edge_fn(longint x0, longint y0, longint x1, longint y1,
			longint px, longint py);
		return (x1 - x0) * (py - y0) - (y1 - y0) * (px - x0);
	endfunction

	function automatic pix_result_t rasterize(cmd_item_t c);
		pix_result_t res;
		int w, h, minx, maxx, miny, maxy;
		longint e1, e2, e3;
		int unsigned idx, cnt;
		logic [31:0] px;
		res = '{0, 0, 0, 0, 0};
		w = fw > 128 ? 128 : int'(fw);
		h = fh > 128 ? 128 : int'(fh);
		if (c.op == OP_READ) begin
			px = 32'hFF000000;
			if (c.ax >= 0 && c.ay >= 0 && c.ax < w && c.ay < h) begin
				idx = c.ay * w + c.ax;
				if (idx < 16384) px = fb_model[idx];
			end
			res.r = px[23:16]; res.g = px[15:8]; res.b = px[7:0]; res.a = px[31:24];
			return res;
		end
		minx = c.ax; if (c.bx < minx) minx = c.bx; if (c.cx < minx) minx = c.cx;
		maxx = c.ax; if (c.bx > maxx) maxx = c.bx; if (c.cx > maxx) maxx = c.cx;
		miny = c.ay; if (c.by < miny) miny = c.by; if (c.cy < miny) miny = c.cy;
		maxy = c.ay; if (c.by > maxy) maxy = c.by; if (c.cy > maxy) maxy = c.cy;
		if (minx < int'(cl)) minx = int'(cl);
		if (miny < int'(ct)) miny = int'(ct);
		if (maxx >= int'(cl + csx)) maxx = int'(cl + csx) - 1;
		if (maxy >= int'(ct + csy)) maxy = int'(ct + csy) - 1;
		if (minx < 0) minx = 0;
		if (miny < 0) miny = 0;
		if (maxx >= w) maxx = w - 1;
		if (maxy >= h) maxy = h - 1;
		if (edge_fn(c.ax, c.ay, c.bx, c.by, c.cx, c.cy) == 0) return res;
		cnt = 0;
		for (int y = miny; y <= maxy; y++)
			for (int x = minx; x <= maxx; x++) begin
				e1 = edge_fn(c.ax, c.ay, c.bx, c.by, x, y);
				e2 = edge_fn(c.bx, c.by, c.cx, c.cy, x, y);
				e3 = edge_fn(c.cx, c.cy, c.ax, c.ay, x, y);
				if ((e1 >= 0 && e2 >= 0 && e3 >= 0) || (e1 <= 0 && e2 <= 0 && e3 <= 0)) begin
					idx = y * w + x;
					if (idx < 16384) begin
						fb_model[idx] = blend_px(fb_model[idx], c);
						if (cnt < 32767) cnt++;
					end
				end
			end
		res.cnt = 15'(cnt);
		return res;
	endfunction

	function automatic cmd_item_t mk_cmd(logic op, int ax, int ay, int bx, int by,
			int cx, int cy, logic [31:0] rgba);
		cmd_item_t c;
		c.op = op;
		c.ax = 16'(ax); c.ay = 16'(ay); c.bx = 16'(bx); c.by = 16'(by);
		c.cx = 16'(cx); c.cy = 16'(cy);
		{c.r, c.g, c.b, c.a} = rgba;
		return c;
	endfunction

	function automatic cmd_item_t rand_cmd(int sz);
		cmd_item_t c;
		int ox, oy;
		c.op = $urandom_range(0, 3) == 0 ? OP_READ : OP_FILL;
		ox = int'($urandom_range(0, 140)) - 6;
		oy = int'($urandom_range(0, 140)) - 6;
		c.ax = 16'(ox); c.ay = 16'(oy);
		c.bx = 16'(ox + int'($urandom_range(0, 2 * sz)) - sz);
		c.by = 16'(oy + int'($urandom_range(0, 2 * sz)) - sz);
		c.cx = 16'(ox + int'($urandom_range(0, 2 * sz)) - sz);
		c.cy = 16'(oy + int'($urandom_range(0, 2 * sz)) - sz);
		if ($urandom_range(0, 15) == 0) begin
			c.ax = 16'($urandom); c.ay = 16'($urandom); c.bx = 16'($urandom);
			c.by = 16'($urandom); c.cx = 16'($urandom); c.cy = 16'($urandom);
		end
		c.r = 8'($urandom); c.g = 8'($urandom); c.b = 8'($urandom);
		case ($urandom_range(0, 3))
			0: c.a = 8'hFF;
			1: c.a = 8'h00;
			default: c.a = 8'($urandom);
		endcase
		return c;
	endfunction

	// driver: bursts and gaps
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (s_tvalid && s_tready) begin
			expected_pix.push_back(rasterize(pending_cmds.pop_front()));
		end
		if (arst_n && !(s_tvalid && !s_tready)) begin
			if (pending_cmds.size() != 0 && !hold_sender && burst_left > 0) begin
				s_tvalid <= 1'b1;
				s_tuser  <= pending_cmds[0].op;
				s_tdata  <= {pending_cmds[0].a, pending_cmds[0].b, pending_cmds[0].g,
					pending_cmds[0].r, pending_cmds[0].cy, pending_cmds[0].cx,
					pending_cmds[0].by, pending_cmds[0].bx, pending_cmds[0].ay,
					pending_cmds[0].ax};
				burst_left <= burst_left - 1;
			end else begin
				s_tvalid <= 1'b0;
				if (gap_left > 0) gap_left <= gap_left - 1;
				else begin
					burst_left <= $urandom_range(1, 8);
					gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
				end
			end
		end
	end

	// monitor and receiver stall pattern
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (expected_pix.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", m_tdata);
			end else begin
				pix_result_t e;
				e = expected_pix.pop_front();
				if (m_tdata[7:0] != e.r || m_tdata[15:8] != e.g || m_tdata[23:16] != e.b ||
						m_tdata[31:24] != e.a || m_tdata[46:32] != e.cnt) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp r%0d g%0d b%0d a%0d n%0d %s",
							e.r, e.g, e.b, e.a, e.cnt, "got:",
							" r%0d g%0d b%0d a%0d n%0d", m_tdata[7:0], m_tdata[15:8],
							m_tdata[23:16], m_tdata[31:24], m_tdata[46:32]);
				end
			end
		end
		m_tready <= (cycles % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
	end

	task automatic drain_all();
		while (pending_cmds.size() != 0 || s_tvalid || expected_pix.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_FRAME_WIDTH:  fw = val;
			REG_FRAME_HEIGHT: fh = val;
			REG_CLIP_LEFT:    cl = val;
			REG_CLIP_TOP:     ct = val;
			REG_CLIP_SPAN_X:  csx = val;
			REG_CLIP_SPAN_Y:  csy = val;
			default: ;
		endcase
	endtask

	task automatic queue_random(int n, int sz);
		cmd_item_t c;
		for (int i = 0; i < n; i++) begin
			c = rand_cmd(sz);
			if (c.op == OP_READ) reads_done++; else fills_done++;
			pending_cmds.push_back(c);
		end
	endtask

	task automatic run_random(int n, int sz);
		cfg_valid <= 1'b0;
		queue_random(n, sz);
		drain_all();
	endtask

	initial begin
		for (int i = 0; i < 16384; i++) fb_model[i] = 32'hFF000000;
		fw = 128; fh = 128; cl = 0; ct = 0; csx = 128; csy = 128;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: full frame, degenerate, blends, extremes, reads in and out of frame
		pending_cmds.push_back(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(OP_FILL, -32768, -32768, 32767, -32768, -32768, 32767,
			32'h102030FF));
		pending_cmds.push_back(mk_cmd(OP_FILL, 0, 0, 10, 10, 20, 20, 32'hFFFFFFFF));
		pending_cmds.push_back(mk_cmd(OP_FILL, 5, 5, 40, 8, 12, 30, 32'hFF0000FF));
		pending_cmds.push_back(mk_cmd(OP_FILL, 5, 5, 12, 30, 40, 8, 32'h00FF0080));
		pending_cmds.push_back(mk_cmd(OP_FILL, 0, 0, 30, 0, 0, 30, 32'hABCDEF00));
		pending_cmds.push_back(mk_cmd(OP_FILL, 127, 127, 200, 127, 127, 200, 32'h0000FF01));
		pending_cmds.push_back(mk_cmd(OP_FILL, 7, 7, 7, 7, 7, 7, 32'hFFFFFFFF));
		pending_cmds.push_back(mk_cmd(OP_READ, 10, 10, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(OP_READ, 127, 127, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(OP_READ, -1, 3, 0, 0, 0, 0, 32'hFFFFFFFF));
		pending_cmds.push_back(mk_cmd(OP_READ, 128, 3, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(OP_READ, 3, 32767, 0, 0, 0, 0, 0));
		drain_all();
		run_random(25, 24);
		// hold off the sender mid-stream until everything has come back
		queue_random(8, 16);
		while (pending_cmds.size() > 4) @(posedge clk);
		hold_sender = 1'b1;
		while (s_tvalid || expected_pix.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		hold_sender = 1'b0;
		drain_all();
		write_reg(REG_CLIP_LEFT, 8'd20); write_reg(REG_CLIP_TOP, 8'd10);
		write_reg(REG_CLIP_SPAN_X, 8'd40); write_reg(REG_CLIP_SPAN_Y, 8'd128);
		write_reg(REG_FRAME_WIDTH, 8'd64); write_reg(REG_FRAME_HEIGHT, 8'd100);
		run_random(25, 40);
		write_reg(REG_FRAME_WIDTH, 8'd255); write_reg(REG_FRAME_HEIGHT, 8'd1);
		write_reg(REG_CLIP_LEFT, 8'd0); write_reg(REG_CLIP_TOP, 8'd0);
		write_reg(REG_CLIP_SPAN_X, 8'd255); write_reg(REG_CLIP_SPAN_Y, 8'd0);
		run_random(10, 40);
		write_reg(REG_CLIP_SPAN_Y, 8'd255); write_reg(REG_FRAME_HEIGHT, 8'd0);
		run_random(6, 20);
		write_reg(REG_FRAME_WIDTH, 8'd1); write_reg(REG_FRAME_HEIGHT, 8'd128);
		write_reg(REG_CLIP_LEFT, 8'd128); write_reg(REG_CLIP_TOP, 8'd128);
		run_random(6, 20);
		write_reg(REG_CLIP_LEFT, 8'd0); write_reg(REG_CLIP_TOP, 8'd0);
		write_reg(REG_FRAME_WIDTH, 8'd128);
		run_random(10, 30);
		$display("covered %0d fills and %0d reads over several frame and clip settings",
			fills_done + 7, reads_done + 6);
		$display("results checked: %0d, mismatches: %0d", results_seen, mismatches);
		if (mismatches == 0 && expected_pix.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		wait (cycles >= 64'd20000000);
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
